// ----- hdl/tjrc_pkg.sv -----
// ----------------------------------------------------------------------------
// tjrc_pkg
// Shared types and constants for the touch joystick radial clamp: event
// codes, actuator format and fixed-point scaling of the length and quotients.
// ----------------------------------------------------------------------------
package tjrc_pkg;

    // touch event codes
    typedef enum logic [1:0] {
        OP_PRESS   = 2'd0,
        OP_MOVE    = 2'd1,
        OP_RELEASE = 2'd2
    } t_op;

    // actuator format: signed Q1.15, magnitude saturates at Q_MAX
    localparam int ACT_BITS = 16;
    localparam int Q_BITS   = 15;
    localparam logic [Q_BITS-1:0] Q_MAX = 15'h7fff;

    // stick radius register
    localparam int RADIUS_BITS = 12;
    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 12'd128;

    // quotient scaling: offset << 15 inside, offset << 23 against the length
    localparam int ACT_FRAC_BITS = 15;
    localparam int LEN_FRAC_BITS = 8;
    localparam int NUM_SHIFT     = ACT_FRAC_BITS + LEN_FRAC_BITS;

    // the squared distance is scaled by 2^16 so the root carries 8 fraction bits
    localparam int RAD_SHIFT = 2 * LEN_FRAC_BITS;

endpackage

// ----- hdl/tjrc_sqrt.sv -----
// ----------------------------------------------------------------------------
// tjrc_sqrt
// Bit-serial integer square root. Two radicand bits enter the partial
// remainder each cycle and one root bit is decided per cycle.
// ----------------------------------------------------------------------------
module tjrc_sqrt #(
    parameter int RAD_BITS = 42
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [RAD_BITS-1:0]   i_radicand,
    output logic                  o_done,
    output logic [RAD_BITS/2-1:0] o_root
);
    localparam int ROOT_BITS = RAD_BITS / 2;
    localparam int REM_BITS  = ROOT_BITS + 3;
    localparam int CNT_BITS  = $clog2(ROOT_BITS + 1);

    logic [RAD_BITS-1:0]  r_rad;
    logic [REM_BITS-1:0]  r_rem;
    logic [ROOT_BITS-1:0] r_root;
    logic [CNT_BITS-1:0]  r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [REM_BITS+1:0]  n_rem_sh;
    logic [REM_BITS+1:0]  w_trial;
    logic                 w_ge;

    // one root digit: bring down a bit pair and try root*4+1
    always_comb begin
        n_rem_sh = {r_rem, r_rad[RAD_BITS-1:RAD_BITS-2]};
        w_trial  = (REM_BITS+2)'({r_root, 2'b01});
        w_ge     = (n_rem_sh >= w_trial);
    end

    // iteration control and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rad  <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CNT_BITS'(ROOT_BITS);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rad  <= {r_rad[RAD_BITS-3:0], 2'b00};
                r_rem  <= w_ge ? REM_BITS'(n_rem_sh - w_trial) : REM_BITS'(n_rem_sh);
                r_root <= {r_root[ROOT_BITS-2:0], w_ge};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ----- hdl/tjrc_div.sv -----
// ----------------------------------------------------------------------------
// tjrc_div
// Bit-serial restoring divider with a saturating quotient. The numerator is
// loaded left-aligned and shifted in one bit per cycle until i_steps bits are used.
// ----------------------------------------------------------------------------
module tjrc_div #(
    parameter int NUM_BITS = 35,
    parameter int DEN_BITS = 21
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [NUM_BITS-1:0]               i_num,
    input  logic [$clog2(NUM_BITS+1)-1:0]     i_steps,
    input  logic [DEN_BITS-1:0]               i_den,
    output logic                              o_done,
    output logic [tjrc_pkg::Q_BITS-1:0]       o_quot
);
    import tjrc_pkg::*;

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] r_num;
    logic [DEN_BITS-1:0] r_den;
    logic [DEN_BITS-1:0] r_rem;
    logic [Q_BITS-1:0]   r_q;
    logic                r_ovf;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [DEN_BITS:0]   n_rem_sh;
    logic                w_ge;

    // one quotient bit per cycle
    always_comb begin
        n_rem_sh = {r_rem, r_num[NUM_BITS-1]};
        w_ge     = (n_rem_sh >= {1'b0, r_den});
    end

    // iteration control and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= '0;
                r_ovf  <= 1'b0;
                r_cnt  <= i_steps;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= {r_num[NUM_BITS-2:0], 1'b0};
                r_rem <= w_ge ? DEN_BITS'(n_rem_sh - {1'b0, r_den}) : DEN_BITS'(n_rem_sh);
                r_q   <= {r_q[Q_BITS-2:0], w_ge};
                // a set bit leaving the top means the quotient exceeds Q_MAX
                r_ovf <= r_ovf | r_q[Q_BITS-1];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_ovf ? Q_MAX : r_q;

endmodule

// ----- hdl/touch_joystick_radial_clamp.sv -----
// ----------------------------------------------------------------------------
// touch_joystick_radial_clamp
// Virtual thumb stick: press latches the center, move turns the offset into
// a Q1.15 actuator vector clamped to unit length, release zeroes it.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+---------------------------
//   in      | to block  | i_in_valid / o_in_stall    | i_op, i_touch_x, i_touch_y
//   out     | from block| o_out_valid / i_out_stall  | o_stick_x, o_stick_y, o_held
//   cfg     | to block  | i_cfg_we                   | i_cfg_wdata (outer radius)
//
// One transaction at a time. Press, release and ignored events pass straight to
// the done state. A move inside the radius is bounded by the serial divider;
// outside it, by the serial square root and then the divider.
// The result sits in an output register, so the next input transaction is
// taken while the previous result is still stalled.
// Synchronous active-low reset clears the state and sets the radius to 128.
// ----------------------------------------------------------------------------
module touch_joystick_radial_clamp #(
    parameter int COORD_BITS = 12
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [1:0]                             i_op,
    input  logic [COORD_BITS-1:0]                  i_touch_x,
    input  logic [COORD_BITS-1:0]                  i_touch_y,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [tjrc_pkg::ACT_BITS-1:0]   o_stick_x,
    output logic signed [tjrc_pkg::ACT_BITS-1:0]   o_stick_y,
    output logic                                   o_held,
    input  logic                                   i_cfg_we,
    input  logic [tjrc_pkg::RADIUS_BITS-1:0]       i_cfg_wdata
);
    import tjrc_pkg::*;

    localparam int SQ_BITS   = 2 * COORD_BITS;
    localparam int D2_BITS   = 2 * COORD_BITS + 1;
    localparam int RR_BITS   = 2 * RADIUS_BITS;
    localparam int CMP_BITS  = (D2_BITS > RR_BITS) ? D2_BITS : RR_BITS;
    localparam int RAD_BITS  = 2 * COORD_BITS + 18;
    localparam int ROOT_BITS = RAD_BITS / 2;
    localparam int NUM_BITS  = COORD_BITS + NUM_SHIFT;
    localparam int STEP_BITS = $clog2(NUM_BITS + 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SQUARE = 7'b0000010,
        S_SUM    = 7'b0000100,
        S_CMP    = 7'b0001000,
        S_SQRT   = 7'b0010000,
        S_DIV    = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state                      r_state;
    logic [RADIUS_BITS-1:0]      r_radius;
    logic                        r_pressed;
    logic [COORD_BITS-1:0]       r_center_x;
    logic [COORD_BITS-1:0]       r_center_y;
    logic signed [ACT_BITS-1:0]  r_act_x;
    logic signed [ACT_BITS-1:0]  r_act_y;
    logic [COORD_BITS-1:0]       r_ax;
    logic [COORD_BITS-1:0]       r_ay;
    logic                        r_neg_x;
    logic                        r_neg_y;
    logic [SQ_BITS-1:0]          r_sqx;
    logic [SQ_BITS-1:0]          r_sqy;
    logic [RR_BITS-1:0]          r_rr;
    logic [D2_BITS-1:0]          r_d2;
    logic                        r_out_valid;
    logic signed [ACT_BITS-1:0]  r_out_x;
    logic signed [ACT_BITS-1:0]  r_out_y;
    logic                        r_out_held;

    logic [COORD_BITS:0]         n_dx;
    logic [COORD_BITS:0]         n_dy;
    logic [COORD_BITS:0]         n_mx;
    logic [COORD_BITS:0]         n_my;
    logic [RADIUS_BITS-1:0]      n_reff;
    logic                        w_inside;
    logic                        w_sqrt_start;
    logic                        w_sqrt_done;
    logic [ROOT_BITS-1:0]        w_root;
    logic                        w_div_start;
    logic                        w_div_done_x;
    logic                        w_div_done_y;
    logic [ROOT_BITS-1:0]        w_den;
    logic [STEP_BITS-1:0]        w_steps;
    logic [Q_BITS-1:0]           w_qx;
    logic [Q_BITS-1:0]           w_qy;
    logic signed [ACT_BITS-1:0]  n_act_x;
    logic signed [ACT_BITS-1:0]  n_act_y;
    logic                        w_out_load;

    // offset from the center as sign and magnitude
    always_comb begin
        n_dx = {1'b0, i_touch_x} - {1'b0, r_center_x};
        n_dy = {1'b0, i_touch_y} - {1'b0, r_center_y};
        n_mx = n_dx[COORD_BITS] ? -n_dx : n_dx;
        n_my = n_dy[COORD_BITS] ? -n_dy : n_dy;
    end

    // a zero radius behaves as one pixel
    assign n_reff   = (r_radius == '0) ? RADIUS_BITS'(1) : r_radius;
    assign w_inside = (CMP_BITS'(r_d2) <= CMP_BITS'(r_rr));

    // unit launches
    assign w_sqrt_start = (r_state == S_CMP) && !w_inside;
    assign w_div_start  = ((r_state == S_CMP) && w_inside) ||
                          ((r_state == S_SQRT) && w_sqrt_done);
    assign w_den        = (r_state == S_CMP) ? ROOT_BITS'(n_reff) : w_root;
    assign w_steps      = (r_state == S_CMP) ? STEP_BITS'(COORD_BITS + ACT_FRAC_BITS)
                                             : STEP_BITS'(NUM_BITS);

    // output register takes the result when empty or being drained
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // apply the offset sign to the saturated quotients
    always_comb begin
        n_act_x = r_neg_x ? -$signed({1'b0, w_qx}) : $signed({1'b0, w_qx});
        n_act_y = r_neg_y ? -$signed({1'b0, w_qy}) : $signed({1'b0, w_qy});
    end

    tjrc_sqrt #(
        .RAD_BITS (RAD_BITS)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sqrt_start),
        .i_radicand (RAD_BITS'({r_d2, {RAD_SHIFT{1'b0}}})),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

    tjrc_div #(
        .NUM_BITS (NUM_BITS),
        .DEN_BITS (ROOT_BITS)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ({r_ax, {NUM_SHIFT{1'b0}}}),
        .i_steps (w_steps),
        .i_den   (w_den),
        .o_done  (w_div_done_x),
        .o_quot  (w_qx)
    );

    tjrc_div #(
        .NUM_BITS (NUM_BITS),
        .DEN_BITS (ROOT_BITS)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ({r_ay, {NUM_SHIFT{1'b0}}}),
        .i_steps (w_steps),
        .i_den   (w_den),
        .o_done  (w_div_done_y),
        .o_quot  (w_qy)
    );

    // sequencer, stick state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_radius    <= RADIUS_RESET;
            r_pressed   <= 1'b0;
            r_center_x  <= '0;
            r_center_y  <= '0;
            r_act_x     <= '0;
            r_act_y     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_radius <= i_cfg_wdata;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_ax    <= n_mx[COORD_BITS-1:0];
                        r_ay    <= n_my[COORD_BITS-1:0];
                        r_neg_x <= n_dx[COORD_BITS];
                        r_neg_y <= n_dy[COORD_BITS];
                        case (i_op)
                            OP_PRESS: begin
                                if (!r_pressed) begin
                                    r_pressed  <= 1'b1;
                                    r_center_x <= i_touch_x;
                                    r_center_y <= i_touch_y;
                                end
                            end
                            OP_RELEASE: begin
                                r_pressed <= 1'b0;
                                r_act_x   <= '0;
                                r_act_y   <= '0;
                            end
                            default: ;
                        endcase
                        r_state <= ((i_op == OP_MOVE) && r_pressed) ? S_SQUARE : S_DONE;
                    end
                end
                S_SQUARE: begin
                    r_sqx   <= r_ax * r_ax;
                    r_sqy   <= r_ay * r_ay;
                    r_rr    <= n_reff * n_reff;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_d2    <= {1'b0, r_sqx} + {1'b0, r_sqy};
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_state <= w_inside ? S_DIV : S_SQRT;
                end
                S_SQRT: begin
                    if (w_sqrt_done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done_x && w_div_done_y) begin
                        r_act_x <= n_act_x;
                        r_act_y <= n_act_y;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_out_x    <= r_act_x;
                        r_out_y    <= r_act_y;
                        r_out_held <= r_pressed;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_stick_x   = r_out_x;
    assign o_stick_y   = r_out_y;
    assign o_held      = r_out_held;

endmodule

// ----- hdl/tjrc_chk.sv -----
// ----------------------------------------------------------------------------
// tjrc_chk
// Port-level checks for the touch joystick radial clamp, bound to the top.
// ----------------------------------------------------------------------------
module tjrc_chk (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 o_in_stall,
    input  logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    input  logic signed [tjrc_pkg::ACT_BITS-1:0] o_stick_x,
    input  logic signed [tjrc_pkg::ACT_BITS-1:0] o_stick_y,
    input  logic                                 o_held
);
    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_stick_x) && $stable(o_stick_y) && $stable(o_held))
        else $error("output transaction changed while stalled");

    // one transaction in flight: accept closes the input
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted while previous transaction in flight");

    // released stick reports a zero actuator
    a_released_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_held |-> (o_stick_x == 16'sd0) && (o_stick_y == 16'sd0))
        else $error("nonzero actuator while released");

    // saturation keeps the actuator symmetric
    a_no_min_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_stick_x != 16'sh8000) && (o_stick_y != 16'sh8000))
        else $error("actuator reached the negative full-scale code");

    // reset empties the output and opens the input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

endmodule

bind touch_joystick_radial_clamp tjrc_chk u_tjrc_chk (.*);

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the touch joystick radial clamp. A queue of touch
// events (press, move, release, the unused code and noise) feeds a clocked
// driver. A behavioral stick model predicts the actuator and held flag of
// each accepted transaction. A clocked monitor compares every result, field
// by field, against the oldest prediction. The stick radius is rewritten
// between phases while the block is drained.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tjrc_pkg::*;

    localparam int COORD_BITS = 12;
    localparam int COORD_MAX = (1 << COORD_BITS) - 1;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_PCT = 8;
    localparam int LONG_HOLD = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 80;
    localparam int NUM_PHASES = 9;
    localparam int PHASE_ITEMS = 215;

    typedef struct {
        logic [1:0]            op;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } touch_event_t;

    typedef struct {
        logic signed [ACT_BITS-1:0] sx;
        logic signed [ACT_BITS-1:0] sy;
        logic                       held;
    } stick_sample_t;

    // dut signals; the bench-driven ones are known from time zero
    logic                          i_clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          o_in_stall;
    logic [1:0]                    op_drv = OP_PRESS;
    logic [COORD_BITS-1:0]         x_drv = '0;
    logic [COORD_BITS-1:0]         y_drv = '0;
    logic                          o_out_valid;
    logic                          out_stall = 1'b0;
    logic signed [ACT_BITS-1:0]    o_stick_x;
    logic signed [ACT_BITS-1:0]    o_stick_y;
    logic                          o_held;
    logic                          cfg_we = 1'b0;
    logic [RADIUS_BITS-1:0]        cfg_wdata = RADIUS_RESET;

    // bench state
    touch_event_t  pending_events[$];
    stick_sample_t expected_sticks[$];
    touch_event_t  drv_event;
    stick_sample_t want;
    bit            gaps_on = 1'b1;
    int            hold_requests = 0;
    int            hold_served = 0;
    int            hold_left = 0;
    int            failures = 0;
    int            quiet_cycles = 0;

    // stick model state
    logic                       model_pressed = 1'b0;
    logic [COORD_BITS-1:0]      model_cx = '0;
    logic [COORD_BITS-1:0]      model_cy = '0;
    logic signed [ACT_BITS-1:0] model_ax = '0;
    logic signed [ACT_BITS-1:0] model_ay = '0;
    logic [RADIUS_BITS-1:0]     model_radius = RADIUS_RESET;

    touch_joystick_radial_clamp #(
        .COORD_BITS (COORD_BITS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (op_drv),
        .i_touch_x   (x_drv),
        .i_touch_y   (y_drv),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_stick_x   (o_stick_x),
        .o_stick_y   (o_stick_y),
        .o_held      (o_held),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // floor of the square root, bit-pair method
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > v) probe >>= 2;
        while (probe != 0) begin
            if (v >= root + probe) begin
                v -= root + probe;
                root = (root >> 1) + probe;
            end else begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    // truncated quotient, saturated to full scale, sign applied
    function automatic logic signed [ACT_BITS-1:0] clamp_quotient(
        input bit neg, input longint unsigned num, input longint unsigned den);
        longint unsigned q;
        logic [ACT_BITS-1:0] mag;
        q = num / den;
        mag = (q > Q_MAX) ? {1'b0, Q_MAX} : q[ACT_BITS-1:0];
        return neg ? ~mag + 1'b1 : mag;
    endfunction

    // advance the stick model by one event and return the reported sample
    function automatic stick_sample_t predict_stick(input touch_event_t ev);
        int dx;
        int dy;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned d2;
        longint unsigned rad;
        longint unsigned len;
        stick_sample_t res;
        case (ev.op)
            OP_PRESS: begin
                if (!model_pressed) begin
                    model_pressed = 1'b1;
                    model_cx = ev.x;
                    model_cy = ev.y;
                end
            end
            OP_MOVE: begin
                if (model_pressed) begin
                    dx = int'(ev.x) - int'(model_cx);
                    dy = int'(ev.y) - int'(model_cy);
                    ax = (dx < 0) ? -dx : dx;
                    ay = (dy < 0) ? -dy : dy;
                    d2 = ax * ax + ay * ay;
                    // zero radius behaves as one pixel
                    rad = (model_radius == 0) ? 1 : model_radius;
                    if (d2 <= rad * rad) begin
                        model_ax = clamp_quotient(dx < 0, ax << ACT_FRAC_BITS, rad);
                        model_ay = clamp_quotient(dy < 0, ay << ACT_FRAC_BITS, rad);
                    end else begin
                        // beyond the rim: normalize by the length
                        len = floor_root(d2 << RAD_SHIFT);
                        model_ax = clamp_quotient(dx < 0, ax << NUM_SHIFT, len);
                        model_ay = clamp_quotient(dy < 0, ay << NUM_SHIFT, len);
                    end
                end
            end
            OP_RELEASE: begin
                model_pressed = 1'b0;
                model_ax = '0;
                model_ay = '0;
            end
            default: ;
        endcase
        res.sx = model_ax;
        res.sy = model_ay;
        res.held = model_pressed;
        return res;
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp_coord(input int v);
        if (v < 0) return '0;
        if (v > COORD_MAX) return COORD_BITS'(COORD_MAX);
        return v[COORD_BITS-1:0];
    endfunction

    function automatic void push_event(input logic [1:0] op, input int x, input int y);
        touch_event_t ev;
        ev.op = op;
        ev.x = clamp_coord(x);
        ev.y = clamp_coord(y);
        pending_events.push_back(ev);
    endfunction

    function automatic int rand_span(input int a);
        return int'($urandom_range(2 * a)) - a;
    endfunction

    // random sessions: press, a run of moves, usually a release; some noise
    task automatic queue_sessions(input int n_items, input int radius);
        int pushed;
        int cx;
        int cy;
        int r;
        int dx;
        int dy;
        int sgn;
        pushed = 0;
        r = (radius == 0) ? 1 : radius;
        while (pushed < n_items) begin
            if ($urandom_range(99) < 85) begin
                cx = $urandom_range(COORD_MAX);
                cy = $urandom_range(COORD_MAX);
                push_event(OP_PRESS, cx, cy);
                pushed++;
                repeat ($urandom_range(10, 1)) begin
                    sgn = $urandom_range(1) ? 1 : -1;
                    case ($urandom_range(4))
                        0: begin
                            dx = rand_span(r);
                            dy = rand_span(r);
                        end
                        1: begin
                            // on the rim
                            case ($urandom_range(2))
                                0: begin dx = sgn * r; dy = 0; end
                                1: begin dx = 0; dy = sgn * r; end
                                default: begin
                                    dx = sgn * (r * 3 / 5);
                                    dy = ($urandom_range(1) ? 1 : -1) * (r * 4 / 5);
                                end
                            endcase
                        end
                        2: begin
                            // at or just past the rim
                            dx = sgn * (r + int'($urandom_range(3)));
                            dy = rand_span(3);
                        end
                        3: begin
                            dx = rand_span(3);
                            dy = rand_span(3);
                        end
                        default: begin
                            dx = int'($urandom_range(COORD_MAX)) - cx;
                            dy = int'($urandom_range(COORD_MAX)) - cy;
                        end
                    endcase
                    push_event(OP_MOVE, cx + dx, cy + dy);
                    pushed++;
                    // stray press while held is ignored
                    if ($urandom_range(99) < 8) begin
                        push_event(OP_PRESS, $urandom_range(COORD_MAX),
                                   $urandom_range(COORD_MAX));
                        pushed++;
                    end
                end
                if ($urandom_range(9) != 0) begin
                    push_event(OP_RELEASE, $urandom_range(COORD_MAX),
                               $urandom_range(COORD_MAX));
                    pushed++;
                end
            end else begin
                push_event(2'($urandom_range(3)), $urandom_range(COORD_MAX),
                           $urandom_range(COORD_MAX));
                pushed++;
            end
        end
    endtask

    // wait until every queued transaction has been taken and answered
    task automatic wait_drained();
        while (pending_events.size() != 0 || in_valid || expected_sticks.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_radius(input logic [RADIUS_BITS-1:0] r);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= r;
        model_radius = r;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [RADIUS_BITS-1:0] radius_for_phase(input int p);
        case (p)
            0: return 12'd1;
            1: return 12'd4095;
            2: return 12'd0;
            3: return 12'd64;
            4: return 12'd128;
            5: return 12'd2000;
            6: return RADIUS_BITS'($urandom_range(4095, 1));
            7: return RADIUS_BITS'($urandom_range(40, 2));
            default: return RADIUS_BITS'($urandom_range(1500, 200));
        endcase
    endfunction

    // sequence of phases
    initial begin
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // directed events at the reset radius
        push_event(OP_MOVE, COORD_MAX, COORD_MAX);
        push_event(OP_RELEASE, 5, 7);
        push_event(OP_UNUSED, COORD_MAX, 0);
        push_event(OP_PRESS, 0, 0);
        push_event(OP_PRESS, COORD_MAX, COORD_MAX);
        push_event(OP_MOVE, 128, 0);
        push_event(OP_MOVE, 0, 128);
        push_event(OP_MOVE, COORD_MAX, COORD_MAX);
        push_event(OP_MOVE, 90, 90);
        push_event(OP_MOVE, 91, 91);
        push_event(OP_MOVE, 0, 0);
        push_event(OP_UNUSED, 1234, 2345);
        push_event(OP_RELEASE, 0, 0);
        push_event(OP_PRESS, COORD_MAX, COORD_MAX);
        push_event(OP_MOVE, 0, 0);
        push_event(OP_MOVE, COORD_MAX - 128, COORD_MAX);
        push_event(OP_MOVE, COORD_MAX, COORD_MAX - 1);
        push_event(OP_RELEASE, COORD_MAX, COORD_MAX);
        push_event(OP_PRESS, 2048, 2048);
        push_event(OP_MOVE, 2048 + 64, 2048 - 64);
        push_event(OP_MOVE, 0, COORD_MAX);
        push_event(OP_RELEASE, 2048, 2048);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_radius(radius_for_phase(p));
            // one phase runs without any gaps on either side
            gaps_on = (p != 3);
            queue_sessions(PHASE_ITEMS, model_radius);
            // long output hold while the sender keeps offering
            if (p == 5) hold_requests++;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_sticks.size() != 0) begin
            $error("%0d results never arrived", expected_sticks.size());
            failures++;
        end
        if (failures == 0) begin
            $display("[touch_joystick_radial_clamp] OK");
        end else begin
            $display("[touch_joystick_radial_clamp] ERROR");
        end
        $finish;
    end

    // driver: predict on acceptance, then offer the next transaction
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                expected_sticks.push_back(predict_stick(drv_event));
            end
            if (!in_valid || !o_in_stall) begin
                if (pending_events.size() != 0 &&
                    !(gaps_on && $urandom_range(99) < IDLE_PCT)) begin
                    drv_event = pending_events.pop_front();
                    in_valid <= 1'b1;
                    op_drv <= drv_event.op;
                    x_drv <= drv_event.x;
                    y_drv <= drv_event.y;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check accepted results, then decide the next stall
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (expected_sticks.size() == 0) begin
                    $error("result with nothing expected: x=%0d y=%0d held=%0b",
                           o_stick_x, o_stick_y, o_held);
                    failures++;
                end else begin
                    want = expected_sticks.pop_front();
                    if (o_stick_x !== want.sx) begin
                        $error("stick_x expected %0d got %0d", want.sx, o_stick_x);
                        failures++;
                    end
                    if (o_stick_y !== want.sy) begin
                        $error("stick_y expected %0d got %0d", want.sy, o_stick_y);
                        failures++;
                    end
                    if (o_held !== want.held) begin
                        $error("held expected %0b got %0b", want.held, o_held);
                        failures++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = LONG_HOLD;
                out_stall <= 1'b1;
            end else begin
                out_stall <= gaps_on && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[touch_joystick_radial_clamp] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// ----- sim.f -----
hdl/tjrc_pkg.sv
hdl/tjrc_sqrt.sv
hdl/tjrc_div.sv
hdl/touch_joystick_radial_clamp.sv
hdl/tjrc_chk.sv
dv/tb_top.sv
